[hdl/ardenc_pkg.sv]
// shared constants and types for the adaptive rice delta encoder
package ardenc_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int QUANT_SHIFT = 6;
  localparam int LEVEL_W     = SAMPLE_W - QUANT_SHIFT;
  localparam int UVAL_W      = LEVEL_W + 1;

  localparam int K_W         = 5;
  localparam int K_MAX       = 16;
  localparam int TAIL_W      = K_MAX + 1;

  localparam int CHUNK_W     = 64;
  localparam int CHUNK_SH    = $clog2(CHUNK_W);
  localparam int CNT_W       = CHUNK_SH + 1;
  localparam int CIDX_W      = 5;
  localparam int LEN_W       = CIDX_W + CHUNK_SH + 1;

  localparam int KAVG_W      = 32;
  localparam int K_FRAC      = 20;
  localparam int KINT_W      = KAVG_W - K_FRAC;
  localparam int K_DECAY     = 1038090;
  localparam int K_DECAY_W   = 20;
  localparam int K_GAIN      = 6765;
  localparam int K_GAIN_W    = 13;
  localparam int PROD_W      = KAVG_W + K_DECAY_W;
  localparam int GAIN_PROD_W = LEN_W + K_GAIN_W;

  localparam int CFG_W       = 5;
  localparam int CFG_RESET   = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [UVAL_W-1:0] uval;
    logic              last;
  } ardenc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ardenc_qstat_t;

endpackage

[hdl/adaptive_rice_delta_encoder.sv]
// top level of the adaptive rice delta encoder
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_stall_o   raw_sample_i, last_sample_i
//  out      source     out_valid_o / out_stall_i code_bits_o, bit_count_o, last_chunk_o
//  cfg      sink       cfg_we_i                  cfg_wdata_i (initial rice k)
//
// in the back end a sample is first pulled from the queue and its code word sized, then
// the word is loaded out as 64-bit chunks; a stalled output holds back the next load;
// the next sample is pulled only after the last chunk of the current one is loaded; the
// running average of k closes its loop on the cycle that last chunk is loaded
// the front end takes a request every cycle until its 2-entry queue is full
// reset is asynchronous active low; the queue empties and k returns to 3.0
// a stalled output holds its chunk while the front keeps accepting requests until the queue is full
module adaptive_rice_delta_encoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ardenc_pkg::SAMPLE_W-1:0]    raw_sample_i,
  input  logic                               last_sample_i,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [ardenc_pkg::CFG_W-1:0]       cfg_wdata_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ardenc_pkg::CHUNK_W-1:0]     code_bits_o,
  output logic [ardenc_pkg::CNT_W-1:0]       bit_count_o,
  output logic                               last_chunk_o
);
  import ardenc_pkg::*;

  // front to queue
  logic          push;
  ardenc_entry_t push_data;
  // queue to back
  logic          pop;
  ardenc_entry_t head;
  ardenc_qstat_t qstat;

  // quantize, delta and zigzag each sample as it arrives
  ardenc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .raw_sample_i  (raw_sample_i),
    .last_sample_i (last_sample_i),
    .qstat_i       (qstat),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // decouples sample intake from long unary runs in the back end
  ardenc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .rd_data_o   (head),
    .stat_o      (qstat)
  );

  // rice coding, chunking and the adaptive k average
  ardenc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (head),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_bits_o  (code_bits_o),
    .bit_count_o  (bit_count_o),
    .last_chunk_o (last_chunk_o)
  );

endmodule

[hdl/ardenc_front.sv]
// front end: quantizer, delta against previous level and zigzag mapping
module ardenc_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic [ardenc_pkg::SAMPLE_W-1:0]    raw_sample_i,
  input  logic                               last_sample_i,
  input  ardenc_pkg::ardenc_qstat_t          qstat_i,
  output logic                               in_stall_o,
  output logic                               push_o,
  output ardenc_pkg::ardenc_entry_t          push_data_o
);
  import ardenc_pkg::*;

  logic signed [SAMPLE_W-1:0] centered;
  logic signed [LEVEL_W-1:0]  level;
  logic signed [LEVEL_W-1:0]  prev_q, prev_d;
  logic signed [UVAL_W-1:0]   resid;
  logic [UVAL_W:0]            twice;
  logic [UVAL_W:0]            zz;

  // subtract the midpoint by flipping the msb, then floor shift
  assign centered = signed'({~raw_sample_i[SAMPLE_W-1], raw_sample_i[SAMPLE_W-2:0]});
  assign level    = centered[SAMPLE_W-1:QUANT_SHIFT];
  assign resid    = {level[LEVEL_W-1], level} - {prev_q[LEVEL_W-1], prev_q};
  assign twice    = {resid, 1'b0};
  assign zz       = twice ^ {(UVAL_W+1){resid[UVAL_W-1]}};

  assign in_stall_o       = qstat_i.full;
  assign push_o           = in_valid_i && !qstat_i.full;
  assign push_data_o.uval = zz[UVAL_W-1:0];
  assign push_data_o.last = last_sample_i;

  always_comb begin
    prev_d = prev_q;
    if (push_o) begin
      prev_d = last_sample_i ? '0 : level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

[hdl/ardenc_queue.sv]
// small fifo between the front end and the code emitter
module ardenc_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  ardenc_pkg::ardenc_entry_t   push_data_i,
  input  logic                        pop_i,
  output ardenc_pkg::ardenc_entry_t   rd_data_o,
  output ardenc_pkg::ardenc_qstat_t   stat_o
);
  import ardenc_pkg::*;

  ardenc_entry_t     slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign rd_data_o    = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hdl/ardenc_back.sv]
// back end: rice parameter, chunk emission and running average update
module ardenc_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ardenc_pkg::ardenc_entry_t           entry_i,
  input  ardenc_pkg::ardenc_qstat_t           qstat_i,
  output logic                                pop_o,
  input  logic                                cfg_we_i,
  input  logic [ardenc_pkg::CFG_W-1:0]        cfg_wdata_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ardenc_pkg::CHUNK_W-1:0]      code_bits_o,
  output logic [ardenc_pkg::CNT_W-1:0]        bit_count_o,
  output logic                                last_chunk_o
);
  import ardenc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic               state_q, state_d;
  logic [CIDX_W-1:0]  chunk_q, chunk_d;
  logic [KAVG_W-1:0]  kavg_q, kavg_d;
  logic [CFG_W-1:0]   cfg_q;
  logic               out_valid_q, out_valid_d;

  // per-code working registers
  logic [UVAL_W-1:0]  zeros_q;
  logic [TAIL_W-1:0]  tail_q;
  logic [LEN_W-1:0]   len_q;
  logic               last_q;
  logic [PROD_W-1:0]  prod_q;

  logic [CHUNK_W-1:0] code_q;
  logic [CNT_W-1:0]   count_q;
  logic               lastc_q;

  // parameter selection
  logic [KINT_W-1:0]  k_int;
  logic [K_W-1:0]     k_sat;
  logic [UVAL_W-1:0]  zeros;
  logic [TAIL_W-1:0]  low_mask;
  logic [TAIL_W-1:0]  tail;
  logic [LEN_W-1:0]   len;

  // chunk slicing
  logic               load;
  logic               done;
  logic [LEN_W-1:0]   start;
  logic [LEN_W-1:0]   remain;
  logic [LEN_W-1:0]   zeros_x;
  logic [LEN_W-1:0]   shamt;
  logic               chunk_last;
  logic [CNT_W-1:0]   n_bits;
  logic [CHUNK_W-1:0] word;
  logic [CHUNK_W-1:0] mask;

  // average update
  logic [GAIN_PROD_W-1:0] gain;
  logic [KAVG_W:0]        sum;
  logic [KAVG_W-1:0]      k_next;

  assign k_int    = kavg_q[KAVG_W-1:K_FRAC];
  assign k_sat    = (k_int > KINT_W'(K_MAX)) ? K_W'(K_MAX) : k_int[K_W-1:0];
  assign zeros    = UVAL_W'(entry_i.uval >> k_sat);
  assign low_mask = (TAIL_W'(1) << k_sat) - TAIL_W'(1);
  assign tail     = {(TAIL_W-1)'(entry_i.uval) & low_mask[TAIL_W-2:0], 1'b1};
  assign len      = LEN_W'(zeros) + LEN_W'(k_sat) + LEN_W'(1);

  assign pop_o = (state_q == ST_IDLE) && !qstat_i.empty;
  assign load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  assign start      = LEN_W'({chunk_q, {CHUNK_SH{1'b0}}});
  assign remain     = len_q - start;
  assign chunk_last = (remain <= LEN_W'(CHUNK_W));
  assign n_bits     = chunk_last ? CNT_W'(remain) : CNT_W'(CHUNK_W);
  assign zeros_x    = LEN_W'(zeros_q);
  assign done       = load && chunk_last;

  always_comb begin
    word  = '0;
    shamt = '0;
    if (zeros_x >= start) begin
      // terminating one still ahead of or inside this chunk
      shamt = zeros_x - start;
      if (shamt < LEN_W'(CHUNK_W)) begin
        word = CHUNK_W'(tail_q) << shamt[CHUNK_SH-1:0];
      end
    end else begin
      shamt = start - zeros_x;
      if (shamt < LEN_W'(CHUNK_W)) begin
        word = CHUNK_W'(tail_q) >> shamt[CHUNK_SH-1:0];
      end
    end
    if (n_bits == CNT_W'(CHUNK_W)) begin
      mask = '1;
    end else begin
      mask = (CHUNK_W'(1) << n_bits[CHUNK_SH-1:0]) - CHUNK_W'(1);
    end
  end

  assign gain   = len_q * K_GAIN_W'(K_GAIN);
  assign sum    = (KAVG_W+1)'(prod_q[K_FRAC +: KAVG_W]) + (KAVG_W+1)'(gain);
  assign k_next = sum[KAVG_W] ? '1 : sum[KAVG_W-1:0];

  always_comb begin
    state_d     = state_q;
    chunk_d     = chunk_q;
    kavg_d      = kavg_q;
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      chunk_d     = chunk_q + CIDX_W'(1);
    end
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          state_d = ST_EMIT;
          chunk_d = '0;
        end
      end
      ST_EMIT: begin
        if (done) begin
          state_d = ST_IDLE;
          kavg_d  = last_q ? (KAVG_W'(cfg_q) << K_FRAC) : k_next;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chunk_q     <= '0;
      kavg_q      <= KAVG_W'(CFG_RESET) << K_FRAC;
      cfg_q       <= CFG_W'(CFG_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chunk_q     <= chunk_d;
      kavg_q      <= kavg_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      zeros_q <= zeros;
      tail_q  <= tail;
      len_q   <= len;
      last_q  <= entry_i.last;
      prod_q  <= kavg_q * K_DECAY_W'(K_DECAY);
    end
    if (load) begin
      code_q  <= word & mask;
      count_q <= n_bits;
      lastc_q <= chunk_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_bits_o  = code_q;
  assign bit_count_o  = count_q;
  assign last_chunk_o = lastc_q;

endmodule

[hdl/ardenc_checker.sv]
// port-level checks for the adaptive rice delta encoder, bound to the top level
module ardenc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] code_bits_o,
  input logic [6:0]  bit_count_o,
  input logic        last_chunk_o
);

  // stalled chunk stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_bits_o)
      && $stable(bit_count_o) && $stable(last_chunk_o))
    else $error("stalled output chunk changed");

  // chunk length in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bit_count_o != 7'd0) && (bit_count_o <= 7'd64))
    else $error("chunk bit count out of range");

  // only the final chunk of a code word may be partial
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_chunk_o |-> bit_count_o == 7'd64)
    else $error("non-final chunk is not full");

  // unused bits above the count are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (bit_count_o < 7'd64) |-> (code_bits_o >> bit_count_o) == 64'd0)
    else $error("code bits set above bit count");

endmodule

bind adaptive_rice_delta_encoder ardenc_checker u_ardenc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .code_bits_o  (code_bits_o),
  .bit_count_o  (bit_count_o),
  .last_chunk_o (last_chunk_o)
);
